@@ src/npr_pkg.sv @@
// ----------------------------------------------------------------------------
// npr_pkg
// Shared types and constants for the nearest position reference lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package npr_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int REF_W       = 16;
   localparam int POS_W       = 16;
   localparam int DIST_W      = 17;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 17;

   // operation codes
   localparam logic FUNC_APPEND = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_CAP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_REF  = 1'b1;

   // register reset values
   localparam logic [DIST_W-1:0] CAP_RESET         = 17'd10000;
   localparam logic [REF_W-1:0]  DEFAULT_REF_RESET = 16'd1;

   typedef struct packed {
      logic             func;
      logic [REF_W-1:0] ref_value;
      logic [POS_W-1:0] position;
   } npr_req_type;

   typedef struct packed {
      logic [REF_W-1:0] nearest_ref;
      logic             matched;
      logic             table_full;
   } npr_rsp_type;

   // search token that walks the row of cells
   typedef struct packed {
      logic              active;
      logic [POS_W-1:0]  position;
      logic [DIST_W-1:0] best;
      logic [REF_W-1:0]  found;
      logic              hit;
   } npr_token_type;

   // entry write into one cell
   typedef struct packed {
      logic             en;
      logic [REF_W-1:0] ref_value;
      logic [POS_W-1:0] position;
   } npr_wr_type;

endpackage

`default_nettype wire

@@ src/npr_cell.sv @@
// ----------------------------------------------------------------------------
// npr_cell
// One table entry plus one stage of the search token path. Compares its own
// position against the passing token and takes over the best match.
// ----------------------------------------------------------------------------
`default_nettype none

module npr_cell
   import npr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire npr_wr_type    wr,
   input  wire logic          used,
   input  wire npr_token_type tok_in,
   output npr_token_type      tok_out
);

   logic [REF_W-1:0]  ref_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  diff;
   logic [DIST_W-1:0] span;
   logic              closer;
   npr_token_type     tok_ff;
   npr_token_type     tok_in_next;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ref_ff <= wr.ref_value;
         pos_ff <= wr.position;
      end
   end

   assign diff   = (pos_ff >= tok_in.position) ? (pos_ff - tok_in.position)
                                                : (tok_in.position - pos_ff);
   assign span   = {1'b0, diff};
   assign closer = used && (span < tok_in.best);

   always_comb begin
      tok_in_next = tok_in;
      if (closer) begin
         tok_in_next.best  = span;
         tok_in_next.found = ref_ff;
         tok_in_next.hit   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in.active;
      end
      tok_ff.position <= tok_in_next.position;
      tok_ff.best     <= tok_in_next.best;
      tok_ff.found    <= tok_in_next.found;
      tok_ff.hit      <= tok_in_next.hit;
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

@@ src/nearest_position_ref_lookup.sv @@
// ----------------------------------------------------------------------------
// nearest_position_ref_lookup
// Table of (reference, position) entries with a nearest-position search.
// ----------------------------------------------------------------------------
// The table is a row of MAX_ENTRIES cells, one entry each, filled in arrival
// order. An append writes the next free cell and its answer passes through the
// done register and then the output register (the answer flags a dropped
// append when the table is full). A query launches a search token that steps
// through one cell per cycle carrying the best distance so far (starting at
// distance_cap); its answer leaves the last cell through the done and output
// registers. The first entry strictly closer than every earlier one wins, else
// default_ref comes back with matched low. One item is in flight at a time: a
// new item is taken only after the last answer enters the output register.
// Register writes belong to idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_position_ref_lookup
   import npr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire npr_req_type           req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output npr_rsp_type                rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [DIST_W-1:0] cap_ff;
   logic [REF_W-1:0]  default_ref_ff;
   logic [CNT_W-1:0]  fill_count_ff;
   logic [CNT_W-1:0]  fill_count_in;
   logic              busy_ff;
   logic              busy_in;
   logic              done_valid_ff;
   logic              done_valid_in;
   npr_rsp_type       done_data_ff;
   npr_rsp_type       done_data_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   npr_rsp_type       rsp_data_ff;
   logic              req_accept;
   logic              append_go;
   logic              query_go;
   logic              table_is_full;
   logic              rsp_load;
   npr_token_type     chain_tok [MAX_ENTRIES+1];
   npr_wr_type        cell_wr   [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] tok_active;

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !req_stall;
   assign append_go  = req_accept && (req_data.func == FUNC_APPEND);
   assign query_go   = req_accept && (req_data.func == FUNC_QUERY);
   assign table_is_full = (fill_count_ff == CNT_W'(MAX_ENTRIES));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff         <= CAP_RESET;
         default_ref_ff <= DEFAULT_REF_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DISTANCE_CAP: cap_ff         <= csr_wdata[DIST_W-1:0];
            CSR_DEFAULT_REF:  default_ref_ff <= csr_wdata[REF_W-1:0];
            default: ;
         endcase
      end
   end

   // launch the search token into the first cell
   always_comb begin
      chain_tok[0].active   = query_go;
      chain_tok[0].position = req_data.position;
      chain_tok[0].best     = cap_ff;
      chain_tok[0].found    = default_ref_ff;
      chain_tok[0].hit      = 1'b0;
   end

   genvar k;
   generate
      for (k = 0; k < MAX_ENTRIES; k++) begin : g_cell
         assign cell_wr[k].en        = append_go && !table_is_full &&
                                       (fill_count_ff == CNT_W'(k));
         assign cell_wr[k].ref_value = req_data.ref_value;
         assign cell_wr[k].position  = req_data.position;
         assign tok_active[k]        = chain_tok[k+1].active;

         npr_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .wr      (cell_wr[k]),
            .used    (CNT_W'(k) < fill_count_ff),
            .tok_in  (chain_tok[k]),
            .tok_out (chain_tok[k+1])
         );
      end
   endgenerate

   assign fill_count_in = (append_go && !table_is_full) ? (fill_count_ff + 1'b1)
                                                        : fill_count_ff;

   // collect the finished answer, then hand it to the output register
   assign rsp_load = done_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      done_valid_in = done_valid_ff;
      done_data_in  = done_data_ff;
      if (rsp_load) begin
         done_valid_in = 1'b0;
      end
      if (append_go) begin
         done_valid_in           = 1'b1;
         done_data_in.nearest_ref = '0;
         done_data_in.matched    = 1'b0;
         done_data_in.table_full = table_is_full;
      end else if (chain_tok[MAX_ENTRIES].active) begin
         done_valid_in           = 1'b1;
         done_data_in.nearest_ref = chain_tok[MAX_ENTRIES].found;
         done_data_in.matched    = chain_tok[MAX_ENTRIES].hit;
         done_data_in.table_full = 1'b0;
      end
   end

   assign busy_in      = req_accept ? 1'b1 : (rsp_load ? 1'b0 : busy_ff);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         busy_ff       <= 1'b0;
         done_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         busy_ff       <= busy_in;
         done_valid_ff <= done_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      done_data_ff <= done_data_in;
      if (rsp_load) begin
         rsp_data_ff <= done_data_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("fill count beyond table size");

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_active) <= 1)
      else $error("more than one search token in the row");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (tok_active == '0) && !done_valid_ff)
      else $error("work in flight while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy_ff)
      else $error("transfer accepted without going busy");

   a_done_needs_busy: assert property (@(posedge clock) disable iff (reset)
      done_valid_ff |-> busy_ff)
      else $error("finished answer without an item in flight");
`endif

endmodule

`default_nettype wire
